[rtl/core/dehpd_pkg.sv]
// dehpd_pkg: shared types and codes for the dwarf eh pointer decoder
// request kinds, status codes, register indexes, encoding fields, phase enum
// no dependencies
`default_nettype none

package dehpd_pkg;

    localparam int DATA_W   = 64;
    localparam int TDATA_IW = 80;
    localparam int TDATA_OW = 72;
    localparam int CFG_IW   = 3;

    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ENC  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_LITTLE_ENDIAN = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_IS_64BIT      = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_IN_FRAME_HDR  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_SECTION_BASE  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_DATA_BASE     = 3'd4;

    localparam logic [7:0] ENC_OMIT = 8'hff;

    localparam logic [3:0] FMT_ABSPTR  = 4'h0;
    localparam logic [3:0] FMT_ULEB128 = 4'h1;
    localparam logic [3:0] FMT_UDATA2  = 4'h2;
    localparam logic [3:0] FMT_UDATA4  = 4'h3;
    localparam logic [3:0] FMT_UDATA8  = 4'h4;
    localparam logic [3:0] FMT_SLEB128 = 4'h9;
    localparam logic [3:0] FMT_SDATA2  = 4'ha;
    localparam logic [3:0] FMT_SDATA4  = 4'hb;
    localparam logic [3:0] FMT_SDATA8  = 4'hc;

    localparam logic [3:0] APP_PCREL   = 4'h1;
    localparam logic [3:0] APP_DATAREL = 4'h3;

    localparam int ENC_SIGNED_BIT = 3;

    localparam logic [3:0] FS_2 = 4'd2;
    localparam logic [3:0] FS_4 = 4'd4;
    localparam logic [3:0] FS_8 = 4'd8;

    localparam logic [7:0] LEB_MAX_SHIFT_BYTES = 8'd10;
    localparam logic [7:0] LEB_MAX_EXT_BYTES   = 8'd9;
    localparam logic [7:0] COUNT_MAX           = 8'd255;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEB   = 2'd1,
        PH_FIXED = 2'd2
    } t_phase;

endpackage

`default_nettype wire

[rtl/core/dwarf_eh_pointer_decoder.sv]
// dwarf_eh_pointer_decoder: a request passes the input register, then decode logic into
// the result register, whose contents drive m_axis
// throughput one request per cycle while m_axis is not stalled; a finished result that waits
// holds the next request in the input register; synchronous active-low reset returns to idle with
// little endian and 64-bit pointers; uses dehpd_pkg
`default_nettype none

module dwarf_eh_pointer_decoder
    import dehpd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // data_byte [7:0], encoding [15:8], datum_offset [79:16]
    input  wire logic [TDATA_IW-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  wire logic [1:0]           s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // value [63:0], bytes_consumed [71:64]
    output logic [TDATA_OW-1:0]       m_axis_tdata,
    // status [1:0]
    output logic [1:0]                m_axis_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IW-1:0]    i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    // configuration
    logic              r_little_endian;
    logic              r_is_64bit;
    logic              r_in_frame_hdr;
    logic [DATA_W-1:0] r_section_base;
    logic [DATA_W-1:0] r_data_base;

    // input register
    logic              r_in_valid;
    logic [1:0]        r_in_req;
    logic [7:0]        r_in_byte;
    logic [7:0]        r_in_enc;
    logic [DATA_W-1:0] r_in_offset;

    // decoder state
    t_phase            r_phase,  n_phase;
    logic [7:0]        r_enc,    n_enc;
    logic [DATA_W-1:0] r_held,   n_held;
    logic [DATA_W-1:0] r_acc,    n_acc;
    logic [7:0]        r_count,  n_count;
    logic [3:0]        r_fs,     n_fs;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [1:0]        r_out_status;
    logic [7:0]        r_out_count;

    logic              advance;
    logic              emit;
    logic [DATA_W-1:0] e_value;
    logic [1:0]        e_status;
    logic [7:0]        e_count;

    // leb128 path
    logic [6:0]        leb_shift;
    logic [5:0]        leb_top;
    logic              leb_in_range;
    logic [DATA_W-1:0] leb_acc;
    logic [DATA_W-1:0] leb_value;
    logic [7:0]        count_sat;

    // fixed path
    logic [DATA_W-1:0] fix_acc;
    logic [7:0]        fix_count;
    logic              fix_done;
    logic [DATA_W-1:0] fix_mask;
    logic [DATA_W-1:0] fix_raw;
    logic              fix_sign;
    logic [DATA_W-1:0] fix_ext;
    logic [DATA_W-1:0] fix_addend;
    logic [DATA_W-1:0] fix_value;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_out_value};
    assign m_axis_tuser  = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_little_endian <= 1'b1;
            r_is_64bit      <= 1'b1;
            r_in_frame_hdr  <= 1'b0;
            r_section_base  <= '0;
            r_data_base     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LITTLE_ENDIAN: r_little_endian <= i_cfg_data[0];
                CFG_IS_64BIT:      r_is_64bit      <= i_cfg_data[0];
                CFG_IN_FRAME_HDR:  r_in_frame_hdr  <= i_cfg_data[0];
                CFG_SECTION_BASE:  r_section_base  <= i_cfg_data;
                CFG_DATA_BASE:     r_data_base     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req    <= s_axis_tuser;
            r_in_byte   <= s_axis_tdata[7:0];
            r_in_enc    <= s_axis_tdata[15:8];
            r_in_offset <= s_axis_tdata[79:16];
        end
    end

    always_comb begin
        leb_shift    = ({3'b000, r_count[3:0]} << 3) - {3'b000, r_count[3:0]};
        leb_top      = leb_shift[5:0] + 6'd6;
        leb_in_range = r_count < LEB_MAX_SHIFT_BYTES;
        leb_acc      = r_acc;
        if (leb_in_range) begin
            leb_acc = r_acc | ({57'b0, r_in_byte[6:0]} << leb_shift[5:0]);
        end
        leb_value = leb_acc;
        if (r_enc[ENC_SIGNED_BIT] && r_count < LEB_MAX_EXT_BYTES && leb_acc[leb_top]) begin
            leb_value = leb_acc | ({DATA_W{1'b1}} << (leb_top + 6'd1));
        end
        count_sat = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + 8'd1;
    end

    always_comb begin
        if (r_little_endian) begin
            fix_acc = r_acc | ({56'b0, r_in_byte} << {r_count[2:0], 3'b000});
        end else begin
            fix_acc = {r_acc[DATA_W-9:0], r_in_byte};
        end
        fix_count = r_count + 8'd1;
        fix_done  = fix_count >= {4'b0000, r_fs};
        case (r_fs)
            FS_2:    fix_mask = {48'b0, {16{1'b1}}};
            FS_4:    fix_mask = {32'b0, {32{1'b1}}};
            default: fix_mask = {DATA_W{1'b1}};
        endcase
        fix_raw = fix_acc & fix_mask;
        case (r_fs)
            FS_2:    fix_sign = fix_raw[15];
            FS_4:    fix_sign = fix_raw[31];
            default: fix_sign = 1'b0;
        endcase
        fix_ext = fix_raw;
        if (r_enc[ENC_SIGNED_BIT] && fix_sign) begin
            fix_ext = fix_raw | ~fix_mask;
        end
        case (r_enc[7:4])
            APP_PCREL:   fix_addend = r_section_base + r_held;
            APP_DATAREL: fix_addend = r_in_frame_hdr ? r_section_base : r_data_base;
            default:     fix_addend = '0;
        endcase
        fix_value = (fix_ext + fix_addend) & fix_mask;
    end

    always_comb begin
        n_phase  = r_phase;
        n_enc    = r_enc;
        n_held   = r_held;
        n_acc    = r_acc;
        n_count  = r_count;
        n_fs     = r_fs;
        emit     = 1'b0;
        e_value  = '0;
        e_status = ST_OK;
        e_count  = '0;
        if (advance) begin
            if (r_in_req == REQ_BEGIN) begin
                n_enc   = r_in_enc;
                n_held  = r_in_offset;
                n_acc   = '0;
                n_count = '0;
                n_fs    = '0;
                n_phase = PH_FIXED;
                if (r_in_enc == ENC_OMIT) begin
                    n_phase = PH_IDLE;
                    emit    = 1'b1;
                end else begin
                    case (r_in_enc[3:0])
                        FMT_ABSPTR:              n_fs = r_is_64bit ? FS_8 : FS_4;
                        FMT_UDATA2, FMT_SDATA2:  n_fs = FS_2;
                        FMT_UDATA4, FMT_SDATA4:  n_fs = FS_4;
                        FMT_UDATA8, FMT_SDATA8:  n_fs = FS_8;
                        FMT_ULEB128, FMT_SLEB128: n_phase = PH_LEB;
                        default: begin
                            n_phase  = PH_IDLE;
                            emit     = 1'b1;
                            e_status = ST_BAD_ENC;
                        end
                    endcase
                end
            end else if (r_phase != PH_IDLE && r_in_req == REQ_END) begin
                n_phase  = PH_IDLE;
                emit     = 1'b1;
                e_status = ST_OVERFLOW;
                e_count  = r_count;
            end else if (r_phase == PH_LEB && r_in_req == REQ_BYTE) begin
                n_acc   = leb_acc;
                n_count = count_sat;
                if (!r_in_byte[7]) begin
                    n_phase = PH_IDLE;
                    emit    = 1'b1;
                    e_value = leb_value;
                    e_count = count_sat;
                end
            end else if (r_phase == PH_FIXED && r_in_req == REQ_BYTE) begin
                n_acc   = fix_acc;
                n_count = fix_count;
                if (fix_done) begin
                    n_phase = PH_IDLE;
                    emit    = 1'b1;
                    e_value = fix_value;
                    e_count = {4'b0000, r_fs};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_enc   <= '0;
            r_held  <= '0;
            r_acc   <= '0;
            r_count <= '0;
            r_fs    <= '0;
        end else begin
            r_phase <= n_phase;
            r_enc   <= n_enc;
            r_held  <= n_held;
            r_acc   <= n_acc;
            r_count <= n_count;
            r_fs    <= n_fs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value  <= e_value;
            r_out_status <= e_status;
            r_out_count  <= e_count;
        end
    end

endmodule

`default_nettype wire

[tb/dwarf_eh_pointer_decoder_test.sv]
// dwarf_eh_pointer_decoder_test: self-checking bench for the dwarf eh pointer decoder
// drives begin/byte/end requests with random gaps and stalls, predicts every result in order
// depends on dehpd_pkg and dwarf_eh_pointer_decoder
`default_nettype none

module dwarf_eh_pointer_decoder_test;
    import dehpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASE_ITEMS    = 230;

    localparam logic [1:0] REQ_UNUSED      = 2'd3;
    localparam logic [3:0] APP_ABS         = 4'h0;
    localparam logic [3:0] FMT_RESERVED_LO = 4'h5;
    localparam logic [3:0] FMT_RESERVED_HI = 4'hf;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [7:0]  consumed;
    } t_ptr_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic [TDATA_IW-1:0] s_data = '0;
    logic [1:0]          s_user = REQ_BEGIN;
    logic                m_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = CFG_LITTLE_ENDIAN;
    logic [DATA_W-1:0]   cfg_data = '0;

    logic                s_axis_tready;
    logic                m_axis_tvalid;
    logic [TDATA_OW-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                o_cfg_ready;

    // decoder state and register copies
    t_phase      dec_phase = PH_IDLE;
    logic [7:0]  dec_enc = '0;
    logic [63:0] dec_offset = '0;
    logic [63:0] dec_acc = '0;
    logic [7:0]  dec_count = '0;
    logic [3:0]  dec_size = '0;
    logic        cfg_le = 1'b1;
    logic        cfg_is64 = 1'b1;
    logic        cfg_in_hdr = 1'b0;
    logic [63:0] cfg_sec_base = '0;
    logic [63:0] cfg_data_base = '0;

    t_ptr_result pending_ptrs[$];

    bit idle_on = 1'b1;
    int rx_hold = 0;
    int rx_stall = 0;
    int quiet = 0;
    int errors = 0;
    int req_count = 0;
    int work_count = 0;
    int result_count = 0;
    int cfg_count = 0;

    always #4 i_clk = ~i_clk;

    dwarf_eh_pointer_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    function automatic logic [63:0] low_mask(input int bits);
        return (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_offset();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            default: return rand64();
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'hff;
            1: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bit is_known_format(input logic [3:0] fmt);
        case (fmt)
            FMT_ABSPTR, FMT_ULEB128, FMT_UDATA2, FMT_UDATA4, FMT_UDATA8,
            FMT_SLEB128, FMT_SDATA2, FMT_SDATA4, FMT_SDATA8: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [3:0] known_format(input int sel);
        case (sel)
            0: return FMT_ABSPTR;
            1: return FMT_ULEB128;
            2: return FMT_UDATA2;
            3: return FMT_UDATA4;
            4: return FMT_UDATA8;
            5: return FMT_SLEB128;
            6: return FMT_SDATA2;
            7: return FMT_SDATA4;
            default: return FMT_SDATA8;
        endcase
    endfunction

    function automatic logic [3:0] random_app();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return APP_ABS;
        if (r < 60) return APP_PCREL;
        if (r < 90) return APP_DATAREL;
        return 4'($urandom);
    endfunction

    // byte count of a well-formed datum; leb lengths mostly short, rarely past saturation
    function automatic int datum_length(input logic [3:0] fmt);
        int r;
        case (fmt)
            FMT_ABSPTR: return cfg_is64 ? 8 : 4;
            FMT_UDATA2, FMT_SDATA2: return 2;
            FMT_UDATA4, FMT_SDATA4: return 4;
            FMT_UDATA8, FMT_SDATA8: return 8;
            default: begin
                r = $urandom_range(0, 99);
                if (r < 80) return $urandom_range(1, 5);
                if (r < 98) return $urandom_range(6, 12);
                return $urandom_range(250, 300);
            end
        endcase
    endfunction

    task automatic push_result(input logic [63:0] v, input logic [1:0] st, input logic [7:0] n);
        t_ptr_result r;
        r.value = v;
        r.status = st;
        r.consumed = n;
        pending_ptrs.push_back(r);
        dec_phase = PH_IDLE;
    endtask

    task automatic decode_request(input logic [1:0] req, input logic [7:0] b,
                                  input logic [7:0] enc, input logic [63:0] off);
        logic [63:0] v;
        int total;
        int n;
        if (req == REQ_BEGIN) begin
            work_count++;
            dec_enc = enc;
            dec_offset = off;
            dec_acc = '0;
            dec_count = '0;
            dec_size = '0;
            dec_phase = PH_IDLE;
            if (enc == ENC_OMIT) begin
                push_result('0, ST_OK, '0);
                return;
            end
            case (enc[3:0])
                FMT_ABSPTR: dec_size = cfg_is64 ? FS_8 : FS_4;
                FMT_UDATA2, FMT_SDATA2: dec_size = FS_2;
                FMT_UDATA4, FMT_SDATA4: dec_size = FS_4;
                FMT_UDATA8, FMT_SDATA8: dec_size = FS_8;
                FMT_ULEB128, FMT_SLEB128: dec_phase = PH_LEB;
                default: push_result('0, ST_BAD_ENC, '0);
            endcase
            if (dec_size != 0)
                dec_phase = PH_FIXED;
            return;
        end
        if (dec_phase == PH_IDLE || req == REQ_UNUSED)
            return;
        work_count++;
        if (req == REQ_END) begin
            push_result('0, ST_OVERFLOW, dec_count);
            return;
        end
        n = dec_count;
        if (dec_phase == PH_LEB) begin
            // payload past bit 63 is dropped, count saturates
            if (n * 7 < 64)
                dec_acc |= {57'd0, b[6:0]} << (n * 7);
            if (dec_count != COUNT_MAX)
                dec_count++;
            if (b[7])
                return;
            v = dec_acc;
            total = (n + 1) * 7;
            if (dec_enc[ENC_SIGNED_BIT] && total < 64 && v[total-1])
                v |= ~low_mask(total);
            push_result(v, ST_OK, dec_count);
        end else begin
            if (cfg_le)
                dec_acc |= {56'd0, b} << ((n % 8) * 8);
            else
                dec_acc = {dec_acc[55:0], b};
            dec_count++;
            if (dec_count < dec_size)
                return;
            total = dec_size * 8;
            v = dec_acc & low_mask(total);
            if (dec_enc[ENC_SIGNED_BIT] && total < 64 && v[total-1])
                v |= ~low_mask(total);
            case (dec_enc[7:4])
                APP_PCREL: v += cfg_sec_base + dec_offset;
                APP_DATAREL: v += cfg_in_hdr ? cfg_sec_base : cfg_data_base;
                default: ;
            endcase
            v &= low_mask(total);
            push_result(v, ST_OK, {4'd0, dec_size});
        end
    endtask

    task automatic send_req(input logic [1:0] req, input logic [7:0] b,
                            input logic [7:0] enc, input logic [63:0] off);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {off, enc, b};
        s_user <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        req_count++;
        decode_request(req, b, enc, off);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk) s_valid <= 1'b0;
        while (pending_ptrs.size() != 0)
            @(posedge i_clk);
        // requests with no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_count++;
        case (idx)
            CFG_LITTLE_ENDIAN: cfg_le = val[0];
            CFG_IS_64BIT: cfg_is64 = val[0];
            CFG_IN_FRAME_HDR: cfg_in_hdr = val[0];
            CFG_SECTION_BASE: cfg_sec_base = val;
            CFG_DATA_BASE: cfg_data_base = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic le, input logic is64, input logic hdr,
                                input logic [63:0] sec, input logic [63:0] dat);
        wait_for_results();
        write_reg(CFG_LITTLE_ENDIAN, {63'd0, le});
        write_reg(CFG_IS_64BIT, {63'd0, is64});
        write_reg(CFG_IN_FRAME_HDR, {63'd0, hdr});
        write_reg(CFG_SECTION_BASE, sec);
        write_reg(CFG_DATA_BASE, dat);
        @(negedge i_clk) cfg_valid <= 1'b0;
    endtask

    task automatic send_random_datum();
        int roll;
        int len;
        int cut;
        logic [7:0] b;
        logic [3:0] fmt;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            do fmt = 4'($urandom); while (is_known_format(fmt));
            send_req(REQ_BEGIN, 8'($urandom), {4'($urandom), fmt}, rand_offset());
            return;
        end
        if (roll < 7) begin
            send_req(REQ_BEGIN, 8'($urandom), ENC_OMIT, rand_offset());
            return;
        end
        if (roll < 10) begin
            send_req(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), rand64());
            return;
        end
        fmt = known_format($urandom_range(0, 8));
        len = datum_length(fmt);
        // some datums are cut short: dropped for the next begin or closed by an end
        cut = (roll < 22) ? $urandom_range(0, len - 1) : len;
        send_req(REQ_BEGIN, 8'($urandom), {random_app(), fmt}, rand_offset());
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 39) == 0)
                send_req(REQ_UNUSED, 8'($urandom), 8'($urandom), rand64());
            b = rand_byte();
            if (fmt == FMT_ULEB128 || fmt == FMT_SLEB128)
                b[7] = (i < len - 1);
            send_req(REQ_BYTE, b, 8'($urandom), rand64());
        end
        if (cut < len && $urandom_range(0, 1) == 1)
            send_req(REQ_END, 8'($urandom), 8'($urandom), rand64());
    endtask

    task automatic test_special_cases();
        // byte, end and unused requests while idle are dropped; then omit and reserved encodings
        send_req(REQ_BYTE, 8'hff, 8'h00, '1);
        send_req(REQ_END, 8'h00, 8'hff, '0);
        send_req(REQ_UNUSED, 8'h5a, 8'ha5, 64'h0123_4567_89ab_cdef);
        send_req(REQ_BEGIN, 8'h00, ENC_OMIT, '1);
        send_req(REQ_BEGIN, 8'h00, {APP_ABS, FMT_RESERVED_LO}, '0);
        send_req(REQ_BEGIN, 8'hff, {APP_PCREL, FMT_RESERVED_HI}, '1);
        // overflow with an unused request in the middle
        send_req(REQ_BEGIN, 8'h00, {APP_ABS, FMT_ULEB128}, '0);
        send_req(REQ_BYTE, 8'hff, 8'h00, '0);
        send_req(REQ_UNUSED, 8'h00, 8'h00, '0);
        send_req(REQ_END, 8'h00, 8'h00, '0);
        // begin while busy drops the partial datum
        send_req(REQ_BEGIN, 8'h00, {APP_ABS, FMT_UDATA8}, '0);
        send_req(REQ_BYTE, 8'h12, 8'h00, '0);
        send_req(REQ_BEGIN, 8'h00, {APP_ABS, FMT_ULEB128}, '0);
        send_req(REQ_BYTE, 8'h00, 8'h00, '0);
        wait_for_results();
    endtask

    task automatic test_fixed_and_leb();
        send_req(REQ_BEGIN, 8'h00, {APP_PCREL, FMT_UDATA2}, '1);
        send_req(REQ_BYTE, 8'hff, 8'h00, '0);
        send_req(REQ_BYTE, 8'hff, 8'h00, '0);
        send_req(REQ_BEGIN, 8'h00, {APP_DATAREL, FMT_SDATA4}, '0);
        send_req(REQ_BYTE, 8'h00, 8'h00, '0);
        send_req(REQ_BYTE, 8'h00, 8'h00, '0);
        send_req(REQ_BYTE, 8'h00, 8'h00, '0);
        send_req(REQ_BYTE, 8'h80, 8'h00, '0);
        send_req(REQ_BEGIN, 8'h00, {APP_ABS, FMT_SLEB128}, '0);
        send_req(REQ_BYTE, 8'h7f, 8'h00, '0);
        wait_for_results();
    endtask

    task automatic test_config_sweep();
        int start;
        for (int p = 0; p < 8; p++) begin
            idle_on = (p % 3 != 2);
            case (p)
                0: apply_config(1'b1, 1'b1, 1'b0, '0, '0);
                1: apply_config(1'b0, 1'b0, 1'b1, '1, '1);
                2: apply_config(1'b1, 1'b0, 1'b0, 64'h8000_0000_0000_0000, 64'd1);
                3: apply_config(1'b0, 1'b1, 1'b0, rand64(), '1);
                default: apply_config(1'($urandom), 1'($urandom), 1'($urandom),
                                      rand64(), rand64());
            endcase
            start = work_count;
            while (work_count - start < PHASE_ITEMS)
                send_random_datum();
        end
        wait_for_results();
    endtask

    task automatic test_backpressure();
        apply_config(1'b1, 1'b0, 1'b1, rand64(), rand64());
        idle_on = 1'b0;
        rx_hold = HOLD_CYCLES;
        repeat (40) send_random_datum();
        wait_for_results();
        idle_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_ptr_result want;
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            if (pending_ptrs.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata[63:0], '0);
            end else begin
                want = pending_ptrs.pop_front();
                if (m_axis_tdata[63:0] !== want.value)
                    report_mismatch("value", m_axis_tdata[63:0], want.value);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", {62'd0, m_axis_tuser}, {62'd0, want.status});
                if (m_axis_tdata[71:64] !== want.consumed)
                    report_mismatch("bytes consumed", {56'd0, m_axis_tdata[71:64]},
                                    {56'd0, want.consumed});
                result_count++;
            end
            rx_stall = idle_on ? $urandom_range(0, 4) : 0;
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results pending",
                     quiet, pending_ptrs.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_special_cases();
        test_fixed_and_leb();
        test_config_sweep();
        test_backpressure();
        wait_for_results();
        $display("covered %0d requests (%0d decoded), %0d results, %0d register writes",
                 req_count, work_count, result_count, cfg_count);
        $display("formats, omit, bad encodings, overflow, restarts, long leb, stalls; %0d errors",
                 errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
